// File: design/tth_pkg.sv
// Package for the task table: types, codes and defaults used by the top level and the LCM unit.
`default_nettype none
package tth_pkg;

  // Default size of the task table.
  localparam int unsigned MaxTasks = 32;

  // Largest hyperperiod value, 2^63-1.
  localparam logic [62:0] HpMax = {63{1'b1}};

  // Request codes.
  localparam logic ReqAdd    = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // Configuration register indexes.
  typedef enum logic {
    CFG_CORE_ID  = 1'b0,
    CFG_EMPTY_HP = 1'b1
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_WRONG     = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Input item.
  typedef struct packed {
    logic        req_type;
    logic [15:0] task_id;
    logic [7:0]  task_core;
    logic [31:0] task_period;
  } tth_in_t;

  // Result item.
  typedef struct packed {
    status_e     status;
    logic [62:0] hyperperiod;
    logic        overflow;
    logic [5:0]  task_count;
  } tth_out_t;

  // Result of one LCM step from the arithmetic unit.
  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [62:0] value;
  } lcm_res_t;

endpackage
`default_nettype wire

// File: design/tth_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tth_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/tth_lcm.sv
// Iterative LCM step: binary gcd, restoring divide and shift-add multiply.
`default_nettype none
module tth_lcm
  import tth_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [62:0] acc_i,
  input  wire logic [31:0] per_i,
  output lcm_res_t         res_o
);

  typedef enum logic [1:0] {L_IDLE, L_GCD, L_DIV, L_MUL} lstate_e;

  lstate_e     state_q, state_d;
  logic [62:0] acc_q, acc_d;
  logic [31:0] per_q, per_d;
  logic [62:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [5:0]  k_q, k_d;
  logic [31:0] g_q, g_d;
  logic [62:0] n_q, n_d;
  logic [31:0] rem_q, rem_d;
  logic [94:0] mc_q, mc_d;
  logic [94:0] pr_q, pr_d;
  logic [31:0] mp_q, mp_d;
  logic [5:0]  cnt_q, cnt_d;
  lcm_res_t    res_q, res_d;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] g_w;

  // Gcd once one operand reaches zero, with the common power of two restored.
  assign g_w = (a_q == 63'd0) ? (b_q << k_q) : (a_q[31:0] << k_q);

  // Restoring divide step.
  assign rem_sh = {rem_q, n_q[62]};
  assign ge     = (rem_sh >= {1'b0, g_q});

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    per_d   = per_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    g_d     = g_q;
    n_d     = n_q;
    rem_d   = rem_q;
    mc_d    = mc_q;
    pr_d    = pr_q;
    mp_d    = mp_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    res_d.done = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          acc_d   = acc_i;
          per_d   = per_i;
          a_d     = acc_i;
          b_d     = per_i;
          k_d     = '0;
          state_d = L_GCD;
        end
      end
      L_GCD: begin
        // One Stein step per cycle.
        if (a_q == 63'd0 || b_q == 32'd0) begin
          g_d     = g_w;
          n_d     = acc_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = L_DIV;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 6'd1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= {31'd0, b_q}) begin
          a_d = a_q - {31'd0, b_q};
        end else begin
          b_d = b_q - a_q[31:0];
        end
      end
      L_DIV: begin
        // One quotient bit per cycle; the remainder stays below the gcd.
        rem_d = ge ? 32'(rem_sh - {1'b0, g_q}) : rem_sh[31:0];
        n_d   = {n_q[61:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd62) begin
          mc_d    = {32'd0, n_q[61:0], ge};
          pr_d    = '0;
          mp_d    = per_q;
          cnt_d   = '0;
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        // One multiplier bit per cycle.
        if (mp_q[0]) begin
          pr_d = pr_q + mc_q;
        end
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          res_d.done  = 1'b1;
          res_d.ovf   = |pr_d[94:63];
          res_d.value = (|pr_d[94:63]) ? HpMax : pr_d[62:0];
          state_d     = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    per_q <= per_d;
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    g_q   <= g_d;
    n_q   <= n_d;
    rem_q <= rem_d;
    mc_q  <= mc_d;
    pr_q  <= pr_d;
    mp_q  <= mp_d;
    cnt_q <= cnt_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// File: design/task_table_hyperperiod.sv
// Top level of the periodic task table with hyperperiod tracking.
//
//  channel | signals                         | direction
//  in      | in_valid_i, in_ready_o, in_data_i | item in
//  out     | out_valid_o, out_ready_i, out_data_o | item out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i  | register write
//
// One item at a time. An add scans all MAX_TASKS entries; once it stores the
// item, the hyperperiod is refolded over the valid entries with the iterative
// gcd, divide and multiply unit. A remove scans and refolds the same way. A
// wrong-core add skips the scan and goes straight to the result. Reset clears
// the valid bits at once; no clearing pass. A finished result waits in the
// output register while out_ready_i is low.
`default_nettype none
module task_table_hyperperiod
  import tth_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasks
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire tth_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output tth_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned IW = AW + 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_TASKS);

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SCHK, S_FRD, S_FCHK, S_LCM, S_DONE
  } state_e;

  state_e           state_q, state_d;
  tth_in_t          req_q, req_d;
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    free_q, free_d;
  logic             free_ok_q, free_ok_d;
  logic             hit_q, hit_d;
  logic [CW-1:0]    count_q, count_d;
  logic [62:0]      acc_q, acc_d;
  logic             any_q, any_d;
  logic             fovf_q, fovf_d;
  logic [62:0]      hp_q, hp_d;
  logic             ovf_q, ovf_d;
  status_e          status_q, status_d;
  logic [7:0]       core_id_q;
  logic [31:0]      empty_hp_q;
  logic             out_valid_q, out_valid_d;
  tth_out_t         out_q, out_d;
  logic             we;
  logic [AW-1:0]    ram_addr;
  logic [47:0]      rdata;
  logic             lcm_start;
  lcm_res_t         lcm_res;
  logic [31:0]      rd_per;
  logic [15:0]      rd_id;
  logic             cur_valid;

  assign ram_addr  = idx_q[AW-1:0];
  assign rd_id     = rdata[47:32];
  assign rd_per    = rdata[31:0];
  assign cur_valid = valid_q[ram_addr];

  // Entry store: id and period of each slot.
  tth_ram #(
    .Width (48),
    .Depth (MAX_TASKS)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_d),
    .wdata_i ({req_q.task_id, req_q.task_period}),
    .raddr_i (ram_addr),
    .rdata_o (rdata)
  );

  // Shared LCM arithmetic.
  tth_lcm u_lcm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lcm_start),
    .acc_i   (acc_q),
    .per_i   (rd_per),
    .res_o   (lcm_res)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // Request sequencer: scan, update, refold, deliver.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    free_d      = free_q;
    free_ok_d   = free_ok_q;
    hit_d       = hit_q;
    count_d     = count_q;
    acc_d       = acc_q;
    any_d       = any_q;
    fovf_d      = fovf_q;
    hp_d        = hp_q;
    ovf_d       = ovf_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    lcm_start   = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          idx_d     = '0;
          hit_d     = 1'b0;
          free_ok_d = 1'b0;
          if (in_data_i.req_type == ReqAdd && in_data_i.task_core != core_id_q) begin
            status_d = ST_WRONG;
            state_d  = S_DONE;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        // Read address is idx_q; data shows up next cycle.
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (cur_valid && rd_id == req_q.task_id) begin
          hit_d = 1'b1;
          if (req_q.req_type == ReqRemove) begin
            valid_d[ram_addr] = 1'b0;
            count_d           = count_d - CW'(1);
          end
        end else if (!cur_valid && !free_ok_q) begin
          free_d    = ram_addr;
          free_ok_d = 1'b1;
        end
        idx_d = idx_q + IW'(1);
        if (idx_q + IW'(1) == LastIdx) begin
          idx_d  = '0;
          any_d  = 1'b0;
          fovf_d = 1'b0;
          if (req_q.req_type == ReqRemove) begin
            status_d = (hit_d) ? ST_REMOVED : ST_NOT_FOUND;
            state_d  = S_FRD;
          end else if (hit_d) begin
            status_d = ST_DUPLICATE;
            state_d  = S_DONE;
          end else if (!free_ok_d) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            we              = 1'b1;
            valid_d[free_d] = 1'b1;
            count_d         = count_q + CW'(1);
            status_d        = ST_ADDED;
            state_d         = S_FRD;
          end
        end else begin
          state_d = S_SRD;
        end
      end
      S_FRD: begin
        // Skip free slots; close the fold after the last slot.
        if (idx_q == LastIdx) begin
          hp_d    = any_q ? acc_q : {31'd0, empty_hp_q};
          ovf_d   = any_q & fovf_q;
          state_d = S_DONE;
        end else if (!cur_valid) begin
          idx_d = idx_q + IW'(1);
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!any_q) begin
          acc_d   = {31'd0, rd_per};
          any_d   = 1'b1;
          idx_d   = idx_q + IW'(1);
          state_d = S_FRD;
        end else if (fovf_q) begin
          idx_d   = idx_q + IW'(1);
          state_d = S_FRD;
        end else if (acc_q == 63'd0 || rd_per == 32'd0) begin
          acc_d   = '0;
          idx_d   = idx_q + IW'(1);
          state_d = S_FRD;
        end else begin
          lcm_start = 1'b1;
          state_d   = S_LCM;
        end
      end
      S_LCM: begin
        if (lcm_res.done) begin
          acc_d   = lcm_res.value;
          fovf_d  = lcm_res.ovf;
          idx_d   = idx_q + IW'(1);
          state_d = S_FRD;
        end
      end
      S_DONE: begin
        // Load the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = status_q;
          out_d.hyperperiod = hp_q;
          out_d.overflow    = ovf_q;
          out_d.task_count  = 6'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, table flags and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      hp_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      core_id_q   <= '0;
      empty_hp_q  <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      hp_q        <= hp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CORE_ID:  core_id_q  <= cfg_wdata_i[7:0];
          CFG_EMPTY_HP: empty_hp_q <= cfg_wdata_i;
          default:      core_id_q  <= core_id_q;
        endcase
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    free_q    <= free_d;
    free_ok_q <= free_ok_d;
    hit_q     <= hit_d;
    acc_q     <= acc_d;
    any_q     <= any_d;
    fovf_q    <= fovf_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
